FILE: rtl/core/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and codes for the k-way sorted list merge unit
// Beat payload types, operation and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package kwm_pkg;

   // default sizing
   localparam int KWM_NUM_LISTS  = 16;
   localparam int KWM_LIST_DEPTH = 64;
   localparam int KWM_VALUE_BITS = 16;

   // operation codes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_POP    = 1'b1;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_ORDER = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic               operation;
      logic [3:0]         list_index;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_value;
      logic [3:0]         source_list;
      logic [1:0]         status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch request beat
      logic app_read;    // read pointers and last value of target list
      logic app_commit;  // check, write and load result of an append
      logic scan_clear;  // restart head scan
      logic scan_issue;  // issue pointer read for next list
      logic pop_commit;  // update winner's pointers and load result
   } kwm_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;   // issuing the last list this cycle
      logic pipe_busy;   // scan pipeline still holds lists
      logic out_free;    // result register can take a new beat
   } kwm_stat_type;

endpackage

FILE: rtl/core/k_way_sorted_list_merge_unit.sv
// ----------------------------------------------------------------------------
// k_way_sorted_list_merge_unit: merge of up to NUM_LISTS ascending lists
// Append beats add values to list tails; pop beats return the smallest head.
// ----------------------------------------------------------------------------
// Every request beat gives exactly one response beat. An append (operation 0)
// puts value at the tail of list list_index and answers status 0, or status 1
// when the list is full or the index is NUM_LISTS or more, or status 2 when the
// value is below the list's last unread element (an empty list takes any
// value); out_value and source_list read zero. Slots are not reused until a
// list drains, at which point its pointers return to zero. A pop (operation 1)
// returns the smallest head over all lists with its list number, the higher
// list winning a tie, or status 3 when every list is empty. Steps: after an
// append is accepted, it reads the pointers and last value of its list, then
// checks, writes and loads its response; after a pop is accepted, it scans
// every list, waits for the scan pipeline to drain, then updates the winner's
// pointers and loads its response. The pop time is set by the head scan,
// which reads the pointer store and then the element store through a
// two-stage pipeline and feeds one shared comparator, one list per cycle.
// The response sits in an output register, so a new request is taken while
// the previous response is still stalled; it is then held only at the point
// of loading its own result. No clearing pass is needed after reset: per-list
// valid bits mark the pointer store, and the element and last-value stores
// are only ever used after being written.
// ----------------------------------------------------------------------------
module k_way_sorted_list_merge_unit import kwm_pkg::*; #(
   parameter int NUM_LISTS  = KWM_NUM_LISTS,
   parameter int LIST_DEPTH = KWM_LIST_DEPTH,
   parameter int VALUE_BITS = KWM_VALUE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // response channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   kwm_cmd_type  cmd;
   kwm_stat_type stat;

   // sequencer: one beat at a time through append or scan steps
   kwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // stores, scan pipeline and the response register
   kwm_datapath #(
      .NUM_LISTS  (NUM_LISTS),
      .LIST_DEPTH (LIST_DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/core/kwm_ctrl.sv
// ----------------------------------------------------------------------------
// kwm_ctrl: sequencing state machine
// Steps one append or pop through the datapath and holds off new beats.
// ----------------------------------------------------------------------------
module kwm_ctrl import kwm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_op,
   output logic         req_stall,
   input  kwm_stat_type stat,
   output kwm_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_APP_RD,
      S_APP_CHK,
      S_POP_SCAN,
      S_POP_DRAIN,
      S_POP_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_op == OP_POP) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = S_POP_SCAN;
               end else begin
                  state_in = S_APP_RD;
               end
            end
         end
         S_APP_RD: begin
            cmd.app_read = 1'b1;
            state_in     = S_APP_CHK;
         end
         S_APP_CHK: begin
            if (stat.out_free) begin
               cmd.app_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_POP_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.scan_last) begin
               state_in = S_POP_DRAIN;
            end
         end
         S_POP_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = S_POP_DONE;
            end
         end
         S_POP_DONE: begin
            if (stat.out_free) begin
               cmd.pop_commit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/kwm_datapath.sv
// ----------------------------------------------------------------------------
// kwm_datapath: list stores, head scan pipeline and result register
// Element, pointer and last-value stores; shared head comparator.
// ----------------------------------------------------------------------------
module kwm_datapath import kwm_pkg::*; #(
   parameter int NUM_LISTS  = KWM_NUM_LISTS,
   parameter int LIST_DEPTH = KWM_LIST_DEPTH,
   parameter int VALUE_BITS = KWM_VALUE_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  kwm_cmd_type  cmd,
   output kwm_stat_type stat,
   input  req_type      req_data,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int LIST_BITS  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int SLOT_BITS  = $clog2(LIST_DEPTH);
   localparam int CNT_BITS   = $clog2(LIST_DEPTH + 1);
   localparam int ELEM_BITS  = LIST_BITS + SLOT_BITS;
   localparam int ELEM_DEPTH = NUM_LISTS * (2 ** SLOT_BITS);

   // request
   req_type                      req_ff;
   logic [LIST_BITS-1:0]         app_list;
   logic                         app_in_range;
   logic signed [VALUE_BITS-1:0] app_val;
   logic                         app_full;
   logic                         app_order;
   logic                         app_ok;

   // pointer store: head and fill per list, valid bit per list
   logic [CNT_BITS-1:0]  head_mem_ff [NUM_LISTS];
   logic [CNT_BITS-1:0]  fill_mem_ff [NUM_LISTS];
   logic [NUM_LISTS-1:0] ptr_vld_ff;
   logic [CNT_BITS-1:0]  head_q_ff;
   logic [CNT_BITS-1:0]  fill_q_ff;
   logic                 ptr_qv_ff;
   logic [CNT_BITS-1:0]  head_rd;
   logic [CNT_BITS-1:0]  fill_rd;
   logic                 ptr_re;
   logic                 ptr_we;
   logic [LIST_BITS-1:0] ptr_raddr;
   logic [LIST_BITS-1:0] ptr_waddr;
   logic [CNT_BITS-1:0]  head_wr;
   logic [CNT_BITS-1:0]  fill_wr;

   // last appended value store
   logic signed [VALUE_BITS-1:0] last_mem_ff [NUM_LISTS];
   logic signed [VALUE_BITS-1:0] last_q_ff;

   // element store
   logic signed [VALUE_BITS-1:0] elem_mem_ff [ELEM_DEPTH];
   logic signed [VALUE_BITS-1:0] elem_q_ff;
   logic                         elem_re;
   logic                         elem_we;
   logic [ELEM_BITS-1:0]         elem_raddr;
   logic [ELEM_BITS-1:0]         elem_waddr;

   // scan pipeline
   logic [LIST_BITS-1:0] scan_cnt_ff;
   logic [LIST_BITS-1:0] scan_cnt_in;
   logic [LIST_BITS-1:0] s1_list_ff;
   logic                 v1_ff;
   logic                 s1_ne;
   logic [LIST_BITS-1:0] s2_list_ff;
   logic                 v2_ff;
   logic                 s2_ne_ff;
   logic [CNT_BITS-1:0]  s2_head_ff;
   logic [CNT_BITS-1:0]  s2_fill_ff;
   logic                 take;

   // running winner
   logic                         found_ff;
   logic signed [VALUE_BITS-1:0] best_ff;
   logic [LIST_BITS-1:0]         best_list_ff;
   logic [CNT_BITS-1:0]          best_head_ff;
   logic [CNT_BITS-1:0]          best_fill_ff;
   logic [CNT_BITS-1:0]          pop_next_head;
   logic                         drained;

   // result register
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    out_free;
   logic    load;

   // ---- append checks ----
   assign app_list     = LIST_BITS'(req_ff.list_index);
   assign app_in_range = 32'(req_ff.list_index) < 32'(NUM_LISTS);
   assign app_val      = VALUE_BITS'($signed(req_ff.value));
   assign head_rd      = ptr_qv_ff ? head_q_ff : '0;
   assign fill_rd      = ptr_qv_ff ? fill_q_ff : '0;
   assign app_full     = !app_in_range || (fill_rd >= CNT_BITS'(LIST_DEPTH));
   assign app_order    = (fill_rd > head_rd) && (app_val < last_q_ff);
   assign app_ok       = !app_full && !app_order;

   // ---- pointer store ports ----
   assign ptr_re        = cmd.app_read || cmd.scan_issue;
   assign ptr_raddr     = cmd.app_read ? app_list : scan_cnt_ff;
   assign ptr_we        = (cmd.app_commit && app_ok) || (cmd.pop_commit && found_ff);
   assign ptr_waddr     = cmd.pop_commit ? best_list_ff : app_list;
   assign pop_next_head = best_head_ff + CNT_BITS'(1);
   assign drained       = pop_next_head >= best_fill_ff;

   always_comb begin
      if (cmd.pop_commit) begin
         head_wr = drained ? '0 : pop_next_head;
         fill_wr = drained ? '0 : best_fill_ff;
      end else begin
         head_wr = head_rd;
         fill_wr = fill_rd + CNT_BITS'(1);
      end
   end

   // ---- element store ports ----
   assign elem_we    = cmd.app_commit && app_ok;
   assign elem_waddr = {app_list, fill_rd[SLOT_BITS-1:0]};
   assign elem_re    = v1_ff;
   assign elem_raddr = {s1_list_ff, head_q_ff[SLOT_BITS-1:0]};

   // ---- scan ----
   assign s1_ne       = ptr_qv_ff && (fill_q_ff > head_q_ff);
   // on a tie the later (higher) list takes over
   assign take        = v2_ff && s2_ne_ff && (!found_ff || (elem_q_ff <= best_ff));
   assign scan_cnt_in = cmd.scan_clear ? '0 :
                        cmd.scan_issue ? scan_cnt_ff + LIST_BITS'(1) : scan_cnt_ff;

   assign stat.scan_last = (scan_cnt_ff == LIST_BITS'(NUM_LISTS - 1));
   assign stat.pipe_busy = v1_ff || v2_ff;
   assign stat.out_free  = out_free;

   // ---- result ----
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = cmd.app_commit || cmd.pop_commit;

   always_comb begin
      rsp_data_in = '0;
      if (cmd.pop_commit) begin
         if (found_ff) begin
            rsp_data_in.out_value   = 16'(best_ff);
            rsp_data_in.source_list = 4'(best_list_ff);
            rsp_data_in.status      = ST_OK;
         end else begin
            rsp_data_in.status = ST_EMPTY;
         end
      end else begin
         if (app_full) begin
            rsp_data_in.status = ST_FULL;
         end else if (app_order) begin
            rsp_data_in.status = ST_ORDER;
         end else begin
            rsp_data_in.status = ST_OK;
         end
      end
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   // ---- stores and payload ----
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (ptr_we) begin
         head_mem_ff[ptr_waddr] <= head_wr;
         fill_mem_ff[ptr_waddr] <= fill_wr;
      end
      if (ptr_re) begin
         head_q_ff <= head_mem_ff[ptr_raddr];
         fill_q_ff <= fill_mem_ff[ptr_raddr];
      end
      if (elem_we) begin
         last_mem_ff[app_list] <= app_val;
      end
      if (cmd.app_read) begin
         last_q_ff <= last_mem_ff[app_list];
      end
      if (elem_we) begin
         elem_mem_ff[elem_waddr] <= app_val;
      end
      if (elem_re) begin
         elem_q_ff <= elem_mem_ff[elem_raddr];
      end
      if (cmd.scan_issue) begin
         s1_list_ff <= scan_cnt_ff;
      end
      if (v1_ff) begin
         s2_list_ff <= s1_list_ff;
         s2_ne_ff   <= s1_ne;
         s2_head_ff <= head_q_ff;
         s2_fill_ff <= fill_q_ff;
      end
      if (take) begin
         best_ff      <= elem_q_ff;
         best_list_ff <= s2_list_ff;
         best_head_ff <= s2_head_ff;
         best_fill_ff <= s2_fill_ff;
      end
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---- control ----
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_vld_ff   <= '0;
         ptr_qv_ff    <= 1'b0;
         scan_cnt_ff  <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ptr_we) begin
            ptr_vld_ff[ptr_waddr] <= 1'b1;
         end
         if (ptr_re) begin
            ptr_qv_ff <= ptr_vld_ff[ptr_raddr];
         end
         scan_cnt_ff  <= scan_cnt_in;
         v1_ff        <= cmd.scan_issue;
         v2_ff        <= v1_ff;
         if (cmd.scan_clear) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // a result is only loaded when the output register can take it
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result loaded over an untaken beat");

   // second scan stage only ever follows the first
   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> $past(v1_ff))
      else $error("scan stage 2 valid without stage 1");

   // pointer store is never written while the scan is reading it
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_issue || v1_ff || v2_ff) |-> !ptr_we)
      else $error("pointer write during head scan");

   // a list is either empty with both pointers at zero, or has head below fill
   a_ptr_shape: assert property (@(posedge clock) disable iff (reset)
      (cmd.app_commit && ptr_qv_ff) |->
         ((head_q_ff < fill_q_ff) || ((head_q_ff == '0) && (fill_q_ff == '0))))
      else $error("inconsistent list pointers");
`endif

endmodule
